### sv/ldf_pkg.sv
// Shared types and constants for the length-prefixed message deframer.
package ldf_pkg;

  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;
  localparam int TDATA_W = 40;
  localparam int TUSER_W = 2;

  localparam logic [WORD_W-1:0] MIN_LEN = 16'd2;
  localparam logic [WORD_W-1:0] ONE_LEN = 16'd1;

  typedef enum logic [2:0] {
    PH_LEN_HI  = 3'd0,
    PH_LEN_LO  = 3'd1,
    PH_TYPE_HI = 3'd2,
    PH_TYPE_LO = 3'd3,
    PH_DATA    = 3'd4,
    PH_SKIP    = 3'd5
  } ldf_phase_t;

  typedef struct packed {
    logic              malformed;
    logic              last;
    logic [WORD_W-1:0] byte_index;
    logic              data_valid;
    logic [BYTE_W-1:0] data_byte;
    logic [WORD_W-1:0] msg_type;
  } ldf_res_t;

endpackage

### sv/ldf_parse.sv
// Header parser: tracks the frame phase and forms at most one result per byte.
module ldf_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic [ldf_pkg::BYTE_W-1:0]    rx_byte,
  output logic                          res_valid,
  output ldf_pkg::ldf_res_t             res
);

  ldf_pkg::ldf_phase_t           phase_r, phase_nxt;
  logic [ldf_pkg::WORD_W-1:0]    remaining_r, remaining_nxt;
  logic [ldf_pkg::BYTE_W-1:0]    length_high_r, length_high_nxt;
  logic [ldf_pkg::WORD_W-1:0]    type_word_r, type_word_nxt;
  logic [ldf_pkg::WORD_W-1:0]    data_count_r, data_count_nxt;
  logic [ldf_pkg::WORD_W-1:0]    len;
  logic [ldf_pkg::WORD_W-1:0]    type_full;
  logic                          rem_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= ldf_pkg::PH_LEN_HI;
      remaining_r   <= '0;
      length_high_r <= '0;
      type_word_r   <= '0;
      data_count_r  <= '0;
    end else if (in_fire) begin
      phase_r       <= phase_nxt;
      remaining_r   <= remaining_nxt;
      length_high_r <= length_high_nxt;
      type_word_r   <= type_word_nxt;
      data_count_r  <= data_count_nxt;
    end
  end

  always_comb begin
    len             = {length_high_r, rx_byte};
    type_full       = {type_word_r[ldf_pkg::WORD_W-1:ldf_pkg::BYTE_W], rx_byte};
    rem_end         = (remaining_r <= ldf_pkg::ONE_LEN);
    phase_nxt       = phase_r;
    remaining_nxt   = remaining_r;
    length_high_nxt = length_high_r;
    type_word_nxt   = type_word_r;
    data_count_nxt  = data_count_r;
    res_valid       = 1'b0;
    res             = '0;
    case (phase_r)
      ldf_pkg::PH_LEN_LO: begin
        if (len < ldf_pkg::MIN_LEN) begin
          res_valid     = 1'b1;
          res.last      = 1'b1;
          res.malformed = 1'b1;
          if (len == ldf_pkg::ONE_LEN) begin
            remaining_nxt = ldf_pkg::ONE_LEN;
            phase_nxt     = ldf_pkg::PH_SKIP;
          end else begin
            remaining_nxt = '0;
            phase_nxt     = ldf_pkg::PH_LEN_HI;
          end
        end else begin
          remaining_nxt = len - ldf_pkg::MIN_LEN;
          phase_nxt     = ldf_pkg::PH_TYPE_HI;
        end
      end
      ldf_pkg::PH_TYPE_HI: begin
        type_word_nxt = {rx_byte, {ldf_pkg::BYTE_W{1'b0}}};
        phase_nxt     = ldf_pkg::PH_TYPE_LO;
      end
      ldf_pkg::PH_TYPE_LO: begin
        type_word_nxt  = type_full;
        data_count_nxt = '0;
        if (remaining_r == '0) begin
          res_valid    = 1'b1;
          res.msg_type = type_full;
          res.last     = 1'b1;
          phase_nxt    = ldf_pkg::PH_LEN_HI;
        end else begin
          phase_nxt = ldf_pkg::PH_DATA;
        end
      end
      ldf_pkg::PH_DATA: begin
        res_valid      = 1'b1;
        res.msg_type   = type_word_r;
        res.data_byte  = rx_byte;
        res.data_valid = 1'b1;
        res.byte_index = data_count_r;
        res.last       = rem_end;
        data_count_nxt = data_count_r + ldf_pkg::ONE_LEN;
        if (rem_end) begin
          remaining_nxt = '0;
          phase_nxt     = ldf_pkg::PH_LEN_HI;
        end else begin
          remaining_nxt = remaining_r - ldf_pkg::ONE_LEN;
        end
      end
      ldf_pkg::PH_SKIP: begin
        if (rem_end) begin
          remaining_nxt = '0;
          phase_nxt     = ldf_pkg::PH_LEN_HI;
        end else begin
          remaining_nxt = remaining_r - ldf_pkg::ONE_LEN;
        end
      end
      default: begin
        length_high_nxt = rx_byte;
        phase_nxt       = ldf_pkg::PH_LEN_LO;
      end
    endcase
  end

endmodule

### sv/ldf_outbuf.sv
// Two-entry output buffer: result register plus skid register.
module ldf_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ldf_pkg::ldf_res_t push_res,
  output logic              buf_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ldf_pkg::ldf_res_t out_res
);

  ldf_pkg::ldf_res_t main_r;
  ldf_pkg::ldf_res_t skid_r;
  logic              main_valid_r;
  logic              skid_valid_r;
  logic              advance;

  assign advance   = !main_valid_r || out_ready;
  assign buf_ready = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (advance) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (push) begin
        main_r <= push_res;
      end
    end else if (push) begin
      skid_r <= push_res;
    end
  end

endmodule

### sv/length_prefixed_message_deframer_core.sv
// Top level of the length-prefixed message deframer.
//
// Input stream: one byte per beat on in_tdata. Each message is a 16-bit
// big-endian length, a 16-bit big-endian type word and (length - 2) data
// bytes. Every data byte leaves as one beat on the output stream with the
// type word, its index and tlast on the final byte. A message with no data
// gives one beat with data_valid low and tlast high. A length below two
// gives one beat with malformed set, and a length of one swallows its byte.
// Apart from these two cases, header bytes give no beat.
// Each beat is registered in the output buffer before it appears on out_*.
// Throughput: one byte per cycle while in_tready is high; the parser updates in the accepting cycle
// and the result is held in a two-entry output buffer.
// When the receiver stalls, one extra result fits in the skid register;
// in_tready drops only once that is full.
// Reset (rst_n low, synchronous) returns the parser to expecting a length
// high byte and empties the output buffer.
module length_prefixed_message_deframer_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [ldf_pkg::BYTE_W-1:0]   in_tdata,   // [7:0] rx_byte
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ldf_pkg::TDATA_W-1:0]  out_tdata,  // [15:0] msg_type, [23:16] data_byte,
                                                   // [39:24] byte_index
  output logic [ldf_pkg::TUSER_W-1:0]  out_tuser,  // [0] data_valid, [1] malformed
  output logic                         out_tlast
);

  logic              in_fire;
  logic              res_valid;
  ldf_pkg::ldf_res_t res;
  ldf_pkg::ldf_res_t out_res;

  assign in_fire = in_tvalid && in_tready;

  ldf_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .rx_byte   (in_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  ldf_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire && res_valid),
    .push_res  (res),
    .buf_ready (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.byte_index, out_res.data_byte, out_res.msg_type};
  assign out_tuser = {out_res.malformed, out_res.data_valid};
  assign out_tlast = out_res.last;

endmodule

### sv/ldf_checker.sv
// Port-level checks for the deframer, bound to the top level.
module ldf_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [ldf_pkg::TDATA_W-1:0]  out_tdata,
  input logic [ldf_pkg::TUSER_W-1:0]  out_tuser,
  input logic                         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_malformed_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0] && (out_tdata == '0))
    else $error("malformed beat not a bare last mark");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("beat without data byte is not last");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind length_prefixed_message_deframer_core ldf_checker u_ldf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
